FILE: design/fbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbp_pkg: shared types and constants for the FEN-to-bitboard parser
// Character codes, square constants, parse phases and the state and result
// records that pass between the step logic, the result register and the top.
// ----------------------------------------------------------------------------
package fbp_pkg;

  localparam int BoardW  = 64;
  localparam int SqW     = 8;
  localparam int CharW   = 8;
  localparam int NBoards = 8;

  localparam logic [SqW-1:0] PlaceStart = 8'd56;
  localparam logic [SqW-1:0] SlashStep  = 8'd16;

  // castling rights squares
  localparam int SqWhiteKing  = 62;
  localparam int SqWhiteQueen = 58;
  localparam int SqBlackKing  = 6;
  localparam int SqBlackQueen = 2;

  // board slots
  localparam logic [2:0] BrdPawn   = 3'd0;
  localparam logic [2:0] BrdKnight = 3'd1;
  localparam logic [2:0] BrdBishop = 3'd2;
  localparam logic [2:0] BrdRook   = 3'd3;
  localparam logic [2:0] BrdQueen  = 3'd4;
  localparam logic [2:0] BrdKing   = 3'd5;
  localparam logic [2:0] BrdWhite  = 3'd6;
  localparam logic [2:0] BrdBlack  = 3'd7;

  // characters
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChUpB   = 8'h42;
  localparam logic [CharW-1:0] ChUpK   = 8'h4B;
  localparam logic [CharW-1:0] ChUpN   = 8'h4E;
  localparam logic [CharW-1:0] ChUpP   = 8'h50;
  localparam logic [CharW-1:0] ChUpQ   = 8'h51;
  localparam logic [CharW-1:0] ChUpR   = 8'h52;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoB   = 8'h62;
  localparam logic [CharW-1:0] ChLoK   = 8'h6B;
  localparam logic [CharW-1:0] ChLoN   = 8'h6E;
  localparam logic [CharW-1:0] ChLoP   = 8'h70;
  localparam logic [CharW-1:0] ChLoQ   = 8'h71;
  localparam logic [CharW-1:0] ChLoR   = 8'h72;
  localparam logic [CharW-1:0] ChLoW   = 8'h77;

  // rank '1' sits at row 7, so row = 56 - rank_char when scaled by 8
  localparam logic signed [11:0] EpRowBase  = 12'sd56;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PLACE,
    PH_SIDE,
    PH_SKIP,
    PH_CFIRST,
    PH_CASTLE,
    PH_EP,
    PH_EPRANK
  } phase_e;

  typedef struct packed {
    phase_e                         phase;
    logic [SqW-1:0]                 sq;
    logic [NBoards-1:0][BoardW-1:0] boards;
    logic [BoardW-1:0]              castle;
    logic                           side;
    logic [CharW-1:0]               file;
  } state_t;

  typedef struct packed {
    logic [NBoards-1:0][BoardW-1:0] boards;
    logic [BoardW-1:0]              castle;
    logic [BoardW-1:0]              passant;
    logic                           white_moves;
    logic                           status;
  } result_t;

endpackage
`default_nettype wire

FILE: design/fbp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbp_in_if: character channel
// One position-string character per transfer, with the start flag.
// ----------------------------------------------------------------------------
interface fbp_in_if import fbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             start_flag;

  modport source (output valid, output char_code, output start_flag, input ready);
  modport sink   (input valid, input char_code, input start_flag, output ready);
endinterface
`default_nettype wire

FILE: design/fbp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbp_out_if: bitboard result channel
// One parsed position per transfer: piece, colour, castling and en passant
// boards with the side to move and the parse status.
// ----------------------------------------------------------------------------
interface fbp_out_if import fbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BoardW-1:0] pawn_board;
  logic [BoardW-1:0] knight_board;
  logic [BoardW-1:0] bishop_board;
  logic [BoardW-1:0] rook_board;
  logic [BoardW-1:0] queen_board;
  logic [BoardW-1:0] king_board;
  logic [BoardW-1:0] white_board;
  logic [BoardW-1:0] black_board;
  logic [BoardW-1:0] castle_board;
  logic [BoardW-1:0] passant_board;
  logic              white_moves;
  logic              parse_status;

  modport source (
    output valid, input ready,
    output pawn_board, output knight_board, output bishop_board, output rook_board,
    output queen_board, output king_board, output white_board, output black_board,
    output castle_board, output passant_board, output white_moves, output parse_status
  );
  modport sink (
    input valid, output ready,
    input pawn_board, input knight_board, input bishop_board, input rook_board,
    input queen_board, input king_board, input white_board, input black_board,
    input castle_board, input passant_board, input white_moves, input parse_status
  );
endinterface
`default_nettype wire

FILE: design/fbp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbp_step: per-character parse logic
// Takes the current parser state and one character, gives the next state
// and, when the string finishes, the result record.
// ----------------------------------------------------------------------------
module fbp_step import fbp_pkg::*; (
  input  state_t           state_i,
  input  logic [CharW-1:0] char_i,
  input  logic             start_i,
  output state_t           state_o,
  output logic             res_valid_o,
  output result_t          res_o
);

  state_t                 st;
  state_t                 nxt;
  logic                   is_piece;
  logic [2:0]             kind;
  logic [2:0]             colour;
  logic [BoardW-1:0]      sq_bit;
  logic signed [11:0]     ep_idx;
  logic                   ep_ok;
  logic [BoardW-1:0]      ep_bit;
  logic                   emit;
  logic                   status;
  logic [BoardW-1:0]      passant;

  // piece letter decode
  always_comb begin
    is_piece = 1'b1;
    kind     = BrdPawn;
    colour   = BrdBlack;
    unique case (char_i)
      ChLoP:   kind = BrdPawn;
      ChLoN:   kind = BrdKnight;
      ChLoB:   kind = BrdBishop;
      ChLoR:   kind = BrdRook;
      ChLoQ:   kind = BrdQueen;
      ChLoK:   kind = BrdKing;
      ChUpP:   begin kind = BrdPawn;   colour = BrdWhite; end
      ChUpN:   begin kind = BrdKnight; colour = BrdWhite; end
      ChUpB:   begin kind = BrdBishop; colour = BrdWhite; end
      ChUpR:   begin kind = BrdRook;   colour = BrdWhite; end
      ChUpQ:   begin kind = BrdQueen;  colour = BrdWhite; end
      ChUpK:   begin kind = BrdKing;   colour = BrdWhite; end
      default: is_piece = 1'b0;
    endcase
  end

  // en passant square from file char and rank char
  always_comb begin
    ep_idx = ((EpRowBase - $signed({4'b0000, char_i})) <<< 3)
             + $signed({4'b0000, state_i.file})
             - $signed({4'b0000, ChLoA});
    ep_ok  = !ep_idx[11] && (ep_idx[10:6] == 5'd0);
    ep_bit = ep_ok ? (BoardW'(1) << ep_idx[5:0]) : '0;
  end

  always_comb begin
    st = state_i;
    if (start_i) begin
      st.phase  = PH_PLACE;
      st.sq     = PlaceStart;
      st.boards = '0;
      st.castle = '0;
      st.side   = 1'b0;
      st.file   = '0;
    end
    sq_bit  = BoardW'(1) << st.sq[5:0];
    nxt     = st;
    emit    = 1'b0;
    status  = 1'b0;
    passant = '0;

    unique case (st.phase)
      PH_IDLE: begin
      end
      PH_PLACE: begin
        if (char_i == ChNul) begin
          emit   = 1'b1;
          status = 1'b1;
        end else if (char_i == ChSpace) begin
          nxt.phase = PH_SIDE;
        end else if (char_i == ChSlash) begin
          nxt.sq = st.sq - SlashStep;
        end else if (char_i >= ChZero && char_i <= ChNine) begin
          nxt.sq = st.sq + (char_i - ChZero);
        end else begin
          // squares beyond the board take no bit but still advance
          if (is_piece && st.sq[7:6] == 2'b00) begin
            nxt.boards[kind]   = st.boards[kind] | sq_bit;
            nxt.boards[colour] = st.boards[colour] | sq_bit;
          end
          nxt.sq = st.sq + 8'd1;
        end
      end
      PH_SIDE: begin
        if (char_i == ChNul) begin
          emit   = 1'b1;
          status = 1'b1;
        end else if (char_i != ChSpace) begin
          nxt.side  = (char_i == ChLoW);
          nxt.phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (char_i == ChNul) begin
          emit   = 1'b1;
          status = 1'b1;
        end else begin
          nxt.phase = PH_CFIRST;
        end
      end
      PH_CFIRST, PH_CASTLE: begin
        if (char_i == ChNul) begin
          emit   = 1'b1;
          status = 1'b1;
        end else if (char_i == ChSpace || (char_i == ChDash && st.phase == PH_CFIRST)) begin
          nxt.phase = PH_EP;
        end else begin
          unique case (char_i)
            ChUpK:   nxt.castle[SqWhiteKing]  = 1'b1;
            ChUpQ:   nxt.castle[SqWhiteQueen] = 1'b1;
            ChLoK:   nxt.castle[SqBlackKing]  = 1'b1;
            ChLoQ:   nxt.castle[SqBlackQueen] = 1'b1;
            default: ;
          endcase
          nxt.phase = PH_CASTLE;
        end
      end
      PH_EP: begin
        if (char_i == ChNul) begin
          emit   = 1'b1;
          status = 1'b1;
        end else if (char_i == ChDash) begin
          emit = 1'b1;
        end else if (char_i != ChSpace) begin
          nxt.file  = char_i;
          nxt.phase = PH_EPRANK;
        end
      end
      PH_EPRANK: begin
        emit    = 1'b1;
        passant = ep_bit;
      end
      default: ;
    endcase

    if (emit) begin
      nxt.phase = PH_IDLE;
    end

    state_o             = nxt;
    res_valid_o         = emit;
    res_o.boards        = st.boards;
    res_o.castle        = st.castle;
    res_o.passant       = passant;
    res_o.white_moves   = st.side;
    res_o.status        = status;
  end

endmodule
`default_nettype wire

FILE: design/fbp_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbp_out_buf: result register
// Holds one finished position until the sink takes it.
// ----------------------------------------------------------------------------
module fbp_out_buf import fbp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  result_t       res_i,
  fbp_out_if.source     out_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.pawn_board    = res_q.boards[BrdPawn];
  assign out_o.knight_board  = res_q.boards[BrdKnight];
  assign out_o.bishop_board  = res_q.boards[BrdBishop];
  assign out_o.rook_board    = res_q.boards[BrdRook];
  assign out_o.queen_board   = res_q.boards[BrdQueen];
  assign out_o.king_board    = res_q.boards[BrdKing];
  assign out_o.white_board   = res_q.boards[BrdWhite];
  assign out_o.black_board   = res_q.boards[BrdBlack];
  assign out_o.castle_board  = res_q.castle;
  assign out_o.passant_board = res_q.passant;
  assign out_o.white_moves   = res_q.white_moves;
  assign out_o.parse_status  = res_q.status;

endmodule
`default_nettype wire

FILE: design/fen_to_bitboard_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fen_to_bitboard_parser: streaming position-string to bitboard parser
// Feed a position string on in_i, one character per transfer; raise
// start_flag on the first character to clear the boards and begin a string.
// The placement field fills the piece and colour boards, then the side
// letter, castling field and en passant square are read. A result transfer
// leaves on out_o when the en passant field is done (parse_status 0) or when
// a NUL arrives earlier (parse_status 1). Characters outside a string are
// dropped without a result.
// The parser state updates at the edge that takes each character; a result
// is valid on out_o the cycle after its last character is taken, and one
// character per cycle is sustained while out_o is drained.
// in_i.ready is low only while a result sits in the output register and the
// sink holds out_o.ready low; the result is then held unchanged.
// Reset leaves the parser idle, waiting for a start flag, with all boards
// cleared and the output register empty.
// ----------------------------------------------------------------------------
module fen_to_bitboard_parser import fbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fbp_in_if.sink    in_i,
  fbp_out_if.source out_o
);

  state_t  state_q;
  state_t  state_d;
  result_t res;
  logic    res_valid;
  logic    in_acc;

  assign in_i.ready = !out_o.valid || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  fbp_step u_step (
    .state_i     (state_q),
    .char_i      (in_i.char_code),
    .start_i     (in_i.start_flag),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase  <= PH_IDLE;
      state_q.sq     <= PlaceStart;
      state_q.boards <= '0;
      state_q.castle <= '0;
      state_q.side   <= 1'b0;
      state_q.file   <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  fbp_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_acc && res_valid),
    .res_i  (res),
    .out_o  (out_o)
  );

`ifndef ASSERT_OFF
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.start_flag && state_q.phase == PH_IDLE) |-> !res_valid)
    else $error("result raised for a character outside a string");

  a_result_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid) |=> (state_q.phase == PH_IDLE))
    else $error("parser not idle after a result");

  a_passant_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot0(out_o.passant_board))
    else $error("more than one en passant bit");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while a result is stalled");
`endif

endmodule
`default_nettype wire

FILE: tb/fen_to_bitboard_parser_tb.sv
// ----------------------------------------------------------------------------
// fen_to_bitboard_parser_tb: self-checking bench for the position parser
// Streams position strings into the parser one character per transfer and
// predicts every board set it should return. A short directed part covers
// the ignored idle input, an immediate NUL, a compact full string and a
// restart mid-string. Random well-formed strings with random content follow,
// cut short or restarted now and then and mixed with noise. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module fen_to_bitboard_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  fbp_in_if  chars_if ();
  fbp_out_if boards_if ();

  fen_to_bitboard_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chars_if),
    .out_o  (boards_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // parser state as predicted
  phase_e           parse_phase;
  logic [SqW-1:0]   square;
  logic [63:0]      piece_brd [NBoards];
  logic [63:0]      castle_rights;
  logic             side_white;
  logic [CharW-1:0] ep_file;

  result_t          expected_boards [$];
  logic [CharW-1:0] text_q [$];

  int items_sent = 0;
  int mismatches = 0;
  int idle_pct   = 31;
  int stall_pct  = 31;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void clear_position();
    for (int i = 0; i < NBoards; i++) piece_brd[i] = '0;
    castle_rights = '0;
    side_white    = 1'b0;
    ep_file       = '0;
    square        = PlaceStart;
  endfunction

  function automatic void post_result(input logic [63:0] passant, input logic status);
    result_t r;
    for (int i = 0; i < NBoards; i++) r.boards[i] = piece_brd[i];
    r.castle      = castle_rights;
    r.passant     = passant;
    r.white_moves = side_white;
    r.status      = status;
    expected_boards.push_back(r);
    parse_phase = PH_IDLE;
  endfunction

  function automatic bit decode_piece(input logic [CharW-1:0] ch,
                                      output logic [2:0] kind, output logic [2:0] colour);
    bit found;
    found  = 1'b1;
    kind   = BrdPawn;
    colour = BrdWhite;
    case (ch)
      ChUpP: kind = BrdPawn;
      ChUpN: kind = BrdKnight;
      ChUpB: kind = BrdBishop;
      ChUpR: kind = BrdRook;
      ChUpQ: kind = BrdQueen;
      ChUpK: kind = BrdKing;
      ChLoP: begin kind = BrdPawn;   colour = BrdBlack; end
      ChLoN: begin kind = BrdKnight; colour = BrdBlack; end
      ChLoB: begin kind = BrdBishop; colour = BrdBlack; end
      ChLoR: begin kind = BrdRook;   colour = BrdBlack; end
      ChLoQ: begin kind = BrdQueen;  colour = BrdBlack; end
      ChLoK: begin kind = BrdKing;   colour = BrdBlack; end
      default: found = 1'b0;
    endcase
    return found;
  endfunction

  // Advance the predicted parser by one character; returns 0 for a dropped one.
  function automatic bit parse_char(input logic [CharW-1:0] ch, input logic st);
    logic [2:0] kind;
    logic [2:0] colour;
    int         row;
    int         idx;
    bit         used;
    used = st || (parse_phase != PH_IDLE);
    if (st) begin
      clear_position();
      parse_phase = PH_PLACE;
    end
    case (parse_phase)
      PH_PLACE: begin
        if (ch == ChNul) post_result('0, 1'b1);
        else if (ch == ChSpace) parse_phase = PH_SIDE;
        else if (ch == ChSlash) square = square - SlashStep;
        else if (ch >= ChZero && ch <= ChNine) square = square + (ch - ChZero);
        else begin
          if (decode_piece(ch, kind, colour) && square < 64) begin
            piece_brd[kind][square[5:0]]   = 1'b1;
            piece_brd[colour][square[5:0]] = 1'b1;
          end
          square = square + 8'd1;
        end
      end
      PH_SIDE: begin
        if (ch == ChNul) post_result('0, 1'b1);
        else if (ch != ChSpace) begin
          side_white  = (ch == ChLoW);
          parse_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (ch == ChNul) post_result('0, 1'b1);
        else parse_phase = PH_CFIRST;
      end
      PH_CFIRST, PH_CASTLE: begin
        if (ch == ChNul) post_result('0, 1'b1);
        else if (ch == ChSpace || (ch == ChDash && parse_phase == PH_CFIRST)) begin
          parse_phase = PH_EP;
        end else begin
          case (ch)
            ChUpK: castle_rights[SqWhiteKing]  = 1'b1;
            ChUpQ: castle_rights[SqWhiteQueen] = 1'b1;
            ChLoK: castle_rights[SqBlackKing]  = 1'b1;
            ChLoQ: castle_rights[SqBlackQueen] = 1'b1;
            default: ;
          endcase
          parse_phase = PH_CASTLE;
        end
      end
      PH_EP: begin
        if (ch == ChNul) post_result('0, 1'b1);
        else if (ch == ChDash) post_result('0, 1'b0);
        else if (ch != ChSpace) begin
          ep_file     = ch;
          parse_phase = PH_EPRANK;
        end
      end
      PH_EPRANK: begin
        // rank '1' is the bottom row, file 'a' the first column
        row = 7 - (int'(ch) - int'(ChZero) - 1);
        idx = row * 8 + int'(ep_file) - int'(ChLoA);
        post_result((idx >= 0 && idx < 64) ? (64'd1 << idx) : 64'd0, 1'b0);
      end
      default: ;
    endcase
    return used;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni === 1'b1 && boards_if.valid === 1'b1 && boards_if.ready === 1'b1) begin
      if (expected_boards.size() == 0) begin
        report_mismatch("unexpected result", boards_if.pawn_board, '0);
      end else begin
        want = expected_boards.pop_front();
        check_field("pawn_board",    boards_if.pawn_board,    want.boards[BrdPawn]);
        check_field("knight_board",  boards_if.knight_board,  want.boards[BrdKnight]);
        check_field("bishop_board",  boards_if.bishop_board,  want.boards[BrdBishop]);
        check_field("rook_board",    boards_if.rook_board,    want.boards[BrdRook]);
        check_field("queen_board",   boards_if.queen_board,   want.boards[BrdQueen]);
        check_field("king_board",    boards_if.king_board,    want.boards[BrdKing]);
        check_field("white_board",   boards_if.white_board,   want.boards[BrdWhite]);
        check_field("black_board",   boards_if.black_board,   want.boards[BrdBlack]);
        check_field("castle_board",  boards_if.castle_board,  want.castle);
        check_field("passant_board", boards_if.passant_board, want.passant);
        check_field("white_moves",   64'(boards_if.white_moves),  64'(want.white_moves));
        check_field("parse_status",  64'(boards_if.parse_status), 64'(want.status));
      end
    end
  end

  // result sink with random back-pressure
  initial begin
    boards_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      boards_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [CharW-1:0] ch, input logic st);
    while ($urandom_range(99) < idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    chars_if.valid      <= 1'b1;
    chars_if.char_code  <= ch;
    chars_if.start_flag <= st;
    @(posedge clk_i);
    while (chars_if.ready !== 1'b1) @(posedge clk_i);
    if (parse_char(ch, st)) items_sent++;
  endtask

  task automatic send_text(input string s, input logic st);
    for (int i = 0; i < s.len(); i++) send_char(s[i], st && i == 0);
  endtask

  // hold the sender until every predicted result has been taken
  task automatic wait_all_results();
    chars_if.valid <= 1'b0;
    while (expected_boards.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CharW-1:0] random_char();
    logic [CharW-1:0] c;
    c = CharW'($urandom_range(1, 255));
    if (c == ChSpace) c = 8'hA0;
    return c;
  endfunction

  function automatic logic [CharW-1:0] random_piece_letter();
    case ($urandom_range(0, 11))
      0:  return ChUpP;
      1:  return ChUpN;
      2:  return ChUpB;
      3:  return ChUpR;
      4:  return ChUpQ;
      5:  return ChUpK;
      6:  return ChLoP;
      7:  return ChLoN;
      8:  return ChLoB;
      9:  return ChLoR;
      10: return ChLoQ;
      default: return ChLoK;
    endcase
  endfunction

  function automatic logic [CharW-1:0] random_castle_letter();
    case ($urandom_range(0, 3))
      0: return ChUpK;
      1: return ChUpQ;
      2: return ChLoK;
      default: return ChLoQ;
    endcase
  endfunction

  // Build one position string into text_q; now and then cut it with a NUL
  // or leave it unfinished so that the next string restarts the parser.
  function automatic void build_position();
    int r;
    int n;
    text_q.delete();
    repeat ($urandom_range(0, 30)) begin
      r = $urandom_range(99);
      if (r < 55) text_q.push_back(random_piece_letter());
      else if (r < 75) text_q.push_back(ChZero + CharW'($urandom_range(0, 9)));
      else if (r < 92) text_q.push_back(ChSlash);
      else text_q.push_back(random_char());
    end
    repeat ($urandom_range(1, 3)) text_q.push_back(ChSpace);
    r = $urandom_range(99);
    text_q.push_back(r < 45 ? ChLoW : (r < 90 ? ChLoB : random_char()));
    text_q.push_back($urandom_range(99) < 80 ? ChSpace : CharW'($urandom_range(1, 255)));
    r = $urandom_range(99);
    if (r < 30) text_q.push_back(ChDash);
    else if (r < 40) text_q.push_back(ChSpace);
    else begin
      repeat ($urandom_range(1, 4)) begin
        text_q.push_back($urandom_range(99) < 90 ? random_castle_letter() : random_char());
      end
      text_q.push_back(ChSpace);
    end
    repeat ($urandom_range(0, 2)) text_q.push_back(ChSpace);
    if ($urandom_range(99) < 35) text_q.push_back(ChDash);
    else begin
      text_q.push_back($urandom_range(99) < 85 ? ChLoA + CharW'($urandom_range(0, 7))
                                               : random_char());
      text_q.push_back($urandom_range(99) < 85 ? ChZero + CharW'($urandom_range(1, 8))
                                               : CharW'($urandom_range(0, 255)));
    end
    r = $urandom_range(99);
    if (r < 15) begin
      n = $urandom_range(0, text_q.size() - 1);
      while (text_q.size() > n) void'(text_q.pop_back());
      text_q.push_back(ChNul);
    end else if (r < 20) begin
      n = $urandom_range(1, text_q.size() - 1);
      while (text_q.size() > n) void'(text_q.pop_back());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_idle_input_dropped();
    send_char(ChUpQ, 1'b0);
    wait_all_results();
  endtask

  task automatic test_nul_on_start();
    send_char(ChNul, 1'b1);
  endtask

  task automatic test_compact_position();
    // dash for castling, en passant on the last square
    send_text("K/p9 wx-h1", 1'b1);
  endtask

  task automatic test_restart_and_early_end();
    send_text("rnR", 1'b1);
    send_text("n b KQzkq ", 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(ChNul, 1'b0);
    wait_all_results();
  endtask

  task automatic test_random_positions();
    int strings;
    bit relaxed;
    strings = 0;
    while (items_sent < 1000) begin
      // long stretch with no idling on either side
      relaxed   = items_sent >= 400 && items_sent < 600;
      idle_pct  = relaxed ? 0 : 31;
      stall_pct = relaxed ? 0 : 31;
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 6)) begin
          send_char(CharW'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
      end else begin
        build_position();
        foreach (text_q[i]) send_char(text_q[i], i == 0);
      end
      strings++;
      if (strings % 40 == 0) wait_all_results();
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    chars_if.valid      <= 1'b0;
    chars_if.char_code  <= '0;
    chars_if.start_flag <= 1'b0;
    clear_position();
    parse_phase = PH_IDLE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_input_dropped();
    test_nul_on_start();
    test_compact_position();
    test_restart_and_early_end();
    test_random_positions();

    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_boards.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: fen_to_bitboard_parser.f
design/fbp_pkg.sv
design/fbp_in_if.sv
design/fbp_out_if.sv
design/fbp_step.sv
design/fbp_out_buf.sv
design/fen_to_bitboard_parser.sv
tb/fen_to_bitboard_parser_tb.sv
